[rtl/edge_heading_goal_yaw_scorer_defines.svh]
// Assertion macros for the RTL of the goal yaw scorer.
// Every check is clocked on aclk and held off while aresetn is low.
`ifndef EDGE_HEADING_GOAL_YAW_SCORER_DEFINES_SVH
`define EDGE_HEADING_GOAL_YAW_SCORER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define EHGYS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define EHGYS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define EHGYS_ASSERT_IMP(lbl, ante, cons)
`define EHGYS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/ehgys_pkg.sv]
package ehgys_pkg;

    // Default and upper bound of the CORDIC step count.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;

    // Width of the raw vectors and of the CORDIC datapath.
    localparam int VW = 36;
    localparam int CW = 44;

    // Normalized vectors have their larger magnitude in [2^40, 2^41).
    localparam logic [5:0] NORM_MSB = 6'd40;

    // Quarter and three-quarter turns in binary angle units.
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

    // One in Q28, for the goal yaw denominator.
    localparam logic signed [VW-1:0] ONE_Q28 = 36'sd268435456;

    // round(pi * 2^29) and the rounding offset for the shift by 47.
    localparam logic [30:0] PI_Q29   = 31'd1686629713;
    localparam logic [62:0] ROUND_47 = 63'h0000_4000_0000_0000;

    // Register reset values.
    localparam logic [14:0] TOL_RESET    = 15'd12868;
    localparam logic [15:0] WEIGHT_RESET = 16'd256;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TOLERANCE = 2'd0,
        CFG_WEIGHT    = 2'd1,
        CFG_THRESHOLD = 2'd2
    } cfg_idx_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_SCORED  = 2'd0,
        ST_PASS    = 2'd1,
        ST_REJECT  = 2'd2,
        ST_NO_GOAL = 2'd3
    } status_t;

    typedef struct packed {
        logic               is_end_edge;
        logic               goal_pose_given;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [30:0] cost;
        logic [14:0] yaw_difference;
    } out_item_t;

    // Item flags that ride along the pipeline.
    typedef struct packed {
        logic end_edge;
        logic given;
    } flags_t;

    // One CORDIC vector with its accumulated angle.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
    } cvec_t;

    // atan(2^-i) in binary angle units (full circle is 2^32).
    function automatic logic [31:0] atan_units(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/edge_heading_goal_yaw_scorer.sv]
// Stages: input register, edge deltas, goal terms, leading-one search, normalization,
// CORDIC steps (count capped at 24), angle difference, radian scaling, output register.
// Throughput: one item per cycle; the two CORDICs are unrolled, one register stage per step.
// The whole pipeline moves together and holds while a result waits to be taken.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register defaults:
// tolerance 12868, weight 256, thresholding off.
`include "edge_heading_goal_yaw_scorer_defines.svh"

module edge_heading_goal_yaw_scorer #(
    parameter int CORDIC_STEPS = ehgys_pkg::CORDIC_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  ehgys_pkg::in_item_t s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ehgys_pkg::out_item_t m_item
);
    import ehgys_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    // Shift amount that brings the leading one of a magnitude to bit 40.
    function automatic logic [5:0] norm_shift(input logic [VW-1:0] m);
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < VW; i++) begin
            if (m[i]) begin
                pos = 6'(i);
            end
        end
        return NORM_MSB - pos;
    endfunction

    // Normalize a vector and rotate it into the right half plane.
    function automatic cvec_t cordic_prep(input logic signed [VW-1:0] x,
                                          input logic signed [VW-1:0] y,
                                          input logic [5:0] sh);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        cvec_t r;
        xs = CW'(x) <<< sh;
        ys = CW'(y) <<< sh;
        r.x = xs;
        r.y = ys;
        r.z = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                r.x = ys;
                r.y = -xs;
                r.z = QUARTER_TURN;
            end else begin
                r.x = -ys;
                r.y = xs;
                r.z = THREE_QUARTER_TURN;
            end
        end
        return r;
    endfunction

    // One vectoring step with floor shifts.
    function automatic cvec_t cordic_step(input cvec_t c, input logic [4:0] i);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        cvec_t r;
        xs = c.x >>> i;
        ys = c.y >>> i;
        if (c.y > 0) begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.z = c.z + atan_units(i);
        end else begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.z = c.z - atan_units(i);
        end
        return r;
    endfunction

    // Configuration registers.
    logic [14:0] tol_reg;
    logic [15:0] weight_reg;
    logic        thr_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg    <= TOL_RESET;
            weight_reg <= WEIGHT_RESET;
            thr_en_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TOLERANCE: tol_reg    <= cfg_wdata[14:0];
                CFG_WEIGHT:    weight_reg <= cfg_wdata;
                CFG_THRESHOLD: thr_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or being taken.
    logic      adv;
    logic      out_valid_reg;
    out_item_t out_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    // Stage 1: input register.
    logic     v1_reg;
    in_item_t in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            in_reg <= s_item;
        end
    end

    // Stage 2: edge deltas and quaternion products.
    logic               v2_reg;
    flags_t             fl2_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic signed [31:0] pwz_reg;
    logic signed [31:0] pxy_reg;
    logic signed [31:0] pyy_reg;
    logic signed [31:0] pzz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg           <= v1_reg;
            fl2_reg.end_edge <= in_reg.is_end_edge;
            fl2_reg.given    <= in_reg.goal_pose_given;
            dx_reg  <= 33'(in_reg.end_x) - 33'(in_reg.start_x);
            dy_reg  <= 33'(in_reg.end_y) - 33'(in_reg.start_y);
            pwz_reg <= in_reg.quat_w * in_reg.quat_z;
            pxy_reg <= in_reg.quat_x * in_reg.quat_y;
            pyy_reg <= in_reg.quat_y * in_reg.quat_y;
            pzz_reg <= in_reg.quat_z * in_reg.quat_z;
        end
    end

    // Stage 3: edge vector and goal yaw numerator and denominator.
    logic               v3_reg;
    flags_t             fl3_reg;
    logic signed [VW-1:0] ex_reg;
    logic signed [VW-1:0] ey_reg;
    logic signed [VW-1:0] gx_reg;
    logic signed [VW-1:0] gy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg  <= v2_reg;
            fl3_reg <= fl2_reg;
            ex_reg  <= VW'(dx_reg);
            ey_reg  <= VW'(dy_reg);
            gy_reg  <= (VW'(pwz_reg) + VW'(pxy_reg)) <<< 1;
            gx_reg  <= ONE_Q28 - ((VW'(pyy_reg) + VW'(pzz_reg)) <<< 1);
        end
    end

    // Stage 4: leading-one search on the larger magnitude of each vector.
    logic [VW-1:0] e_or;
    logic [VW-1:0] g_or;

    always_comb begin
        e_or = VW'(ex_reg < 0 ? -ex_reg : ex_reg) | VW'(ey_reg < 0 ? -ey_reg : ey_reg);
        g_or = VW'(gx_reg < 0 ? -gx_reg : gx_reg) | VW'(gy_reg < 0 ? -gy_reg : gy_reg);
    end

    logic               v4_reg;
    flags_t             fl4_reg;
    logic signed [VW-1:0] ex4_reg;
    logic signed [VW-1:0] ey4_reg;
    logic signed [VW-1:0] gx4_reg;
    logic signed [VW-1:0] gy4_reg;
    logic [5:0]         esh_reg;
    logic [5:0]         gsh_reg;
    logic               ez4_reg;
    logic               gz4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg  <= v3_reg;
            fl4_reg <= fl3_reg;
            ex4_reg <= ex_reg;
            ey4_reg <= ey_reg;
            gx4_reg <= gx_reg;
            gy4_reg <= gy_reg;
            esh_reg <= norm_shift(e_or);
            gsh_reg <= norm_shift(g_or);
            ez4_reg <= (e_or == '0);
            gz4_reg <= (g_or == '0);
        end
    end

    // CORDIC chain: entry 0 is the normalized vector, entry k+1 follows step k.
    logic   cv_reg  [0:NSTEP];
    flags_t cfl_reg [0:NSTEP];
    logic   cez_reg [0:NSTEP];
    logic   cgz_reg [0:NSTEP];
    cvec_t  ce_reg  [0:NSTEP];
    cvec_t  cg_reg  [0:NSTEP];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (adv) begin
            cv_reg[0]  <= v4_reg;
            cfl_reg[0] <= fl4_reg;
            cez_reg[0] <= ez4_reg;
            cgz_reg[0] <= gz4_reg;
            ce_reg[0]  <= cordic_prep(ex4_reg, ey4_reg, esh_reg);
            cg_reg[0]  <= cordic_prep(gx4_reg, gy4_reg, gsh_reg);
        end
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                cv_reg[k+1]  <= cv_reg[k];
                cfl_reg[k+1] <= cfl_reg[k];
                cez_reg[k+1] <= cez_reg[k];
                cgz_reg[k+1] <= cgz_reg[k];
                ce_reg[k+1]  <= cordic_step(ce_reg[k], 5'(k));
                cg_reg[k+1]  <= cordic_step(cg_reg[k], 5'(k));
            end
        end
    end

    // Difference of the two angles and its absolute value; a zero vector has angle 0.
    logic [31:0] edge_ang;
    logic [31:0] goal_ang;
    logic [31:0] diff;

    always_comb begin
        edge_ang = cez_reg[NSTEP] ? 32'd0 : ce_reg[NSTEP].z;
        goal_ang = cgz_reg[NSTEP] ? 32'd0 : cg_reg[NSTEP].z;
        diff     = goal_ang - edge_ang;
    end

    logic        vd1_reg;
    flags_t      fld1_reg;
    logic [31:0] du_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd1_reg <= 1'b0;
        end else if (adv) begin
            vd1_reg  <= cv_reg[NSTEP];
            fld1_reg <= cfl_reg[NSTEP];
            du_reg   <= diff[31] ? (~diff + 32'd1) : diff;
        end
    end

    // Conversion to radians scaled by 8192, rounded half up.
    logic        vd2_reg;
    flags_t      fld2_reg;
    logic [62:0] rad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd2_reg <= 1'b0;
        end else if (adv) begin
            vd2_reg  <= vd1_reg;
            fld2_reg <= fld1_reg;
            rad_reg  <= 63'(du_reg) * 63'(PI_Q29) + ROUND_47;
        end
    end

    // Threshold check, cost and result status.
    logic [14:0] d;
    out_item_t   res;

    always_comb begin
        d   = rad_reg[61:47];
        res = '{status: ST_SCORED, cost: '0, yaw_difference: '0};
        if (!fld2_reg.given) begin
            res.status = ST_NO_GOAL;
        end else if (!fld2_reg.end_edge) begin
            res.status = ST_PASS;
        end else if (thr_en_reg && (d > tol_reg)) begin
            res.status         = ST_REJECT;
            res.yaw_difference = d;
        end else begin
            res.yaw_difference = d;
            res.cost           = 31'(weight_reg) * 31'(d);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vd2_reg;
            out_reg       <= res;
        end
    end

    // A rejection only happens with thresholding on and the difference over tolerance.
    `EHGYS_ASSERT_IMP(a_reject_cause, m_valid && (m_item.status == ST_REJECT),
                      thr_en_reg && (m_item.yaw_difference > tol_reg))
    // Pass and no-goal results carry no cost and no difference.
    `EHGYS_ASSERT_IMP(a_no_cost,
                      m_valid && ((m_item.status == ST_PASS) || (m_item.status == ST_NO_GOAL)),
                      (m_item.cost == '0) && (m_item.yaw_difference == '0))
    // A waiting result stays offered and unchanged until it is taken.
    `EHGYS_ASSERT_NXT(a_stall_holds, m_valid && !m_ready, m_valid && $stable(m_item))

endmodule

[tb/yaw_score_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the register port of the goal yaw scorer,
// predicts each result and compares it with what the block returns.
module yaw_score_checker #(
    parameter int CORDIC_STEPS = ehgys_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  ehgys_pkg::in_item_t  s_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  ehgys_pkg::out_item_t m_item,
    output int                   mismatches,
    output int                   outstanding
);
    import ehgys_pkg::*;

    // atan(2^-i) with the full circle as 2^32.
    localparam logic [31:0] ATAN_LUT [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };
    localparam longint unsigned PI_SCALED = 64'd1686629713;

    logic [14:0] tolerance;
    logic [15:0] weight;
    logic        thresh_on;
    out_item_t   expected_results [$];

    // Angle of (x, y) in binary angle units; a zero vector has angle 0.
    function automatic logic [31:0] heading_units(input longint x, input longint y);
        longint ax, ay, m, t, xs, ys;
        int     n, steps;
        logic [31:0] z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        z = '0;
        if (m == 0) return '0;
        // Normalize so the larger magnitude reaches 2^40.
        while (m < (longint'(1) << 40)) begin
            m = m * 2;
            x = x * 2;
            y = y * 2;
        end
        // Pre-rotate by a quarter turn into the right half plane.
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = QUARTER_TURN;
            end else begin
                t = x; x = -y; y = t; z = THREE_QUARTER_TURN;
            end
        end
        steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        for (n = 0; n < steps; n++) begin
            xs = x >>> n;
            ys = y >>> n;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_LUT[n];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_LUT[n];
            end
        end
        return z;
    endfunction

    // Expected result for one edge under the current register settings.
    function automatic out_item_t score_edge(input in_item_t it);
        out_item_t r;
        longint qx, qy, qz, qw, num, den;
        logic [31:0] edge_ang, goal_ang, diff, mag_units;
        longint unsigned d;
        r = '0;
        if (!it.goal_pose_given) begin
            r.status = ST_NO_GOAL;
            return r;
        end
        if (!it.is_end_edge) begin
            r.status = ST_PASS;
            return r;
        end
        qx = it.quat_x; qy = it.quat_y; qz = it.quat_z; qw = it.quat_w;
        edge_ang = heading_units(longint'(it.end_x) - longint'(it.start_x),
                                 longint'(it.end_y) - longint'(it.start_y));
        num = 2 * (qw * qz + qx * qy);
        den = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
        goal_ang = heading_units(den, num);
        diff = goal_ang - edge_ang;
        // Two's complement wrap; a half turn stays a half turn.
        mag_units = diff[31] ? (~diff + 32'd1) : diff;
        d = (longint'(mag_units) * PI_SCALED + (64'd1 << 46)) >> 47;
        r.yaw_difference = d[14:0];
        if (thresh_on && d > tolerance) begin
            r.status = ST_REJECT;
            return r;
        end
        r.status = ST_SCORED;
        r.cost = 31'(longint'(weight) * d);
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t exp_r;
        if (!aresetn) begin
            tolerance = TOL_RESET;
            weight = WEIGHT_RESET;
            thresh_on = 1'b0;
            expected_results.delete();
            mismatches = 0;
        end else begin
            // Check the result handed over on this edge.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d cost=%0d yaw=%0d",
                             $time, m_item.status, m_item.cost, m_item.yaw_difference);
                    mismatches++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_item.status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, m_item.status);
                        mismatches++;
                    end
                    if (m_item.cost !== exp_r.cost) begin
                        $display("%0t: cost expected %0d actual %0d",
                                 $time, exp_r.cost, m_item.cost);
                        mismatches++;
                    end
                    if (m_item.yaw_difference !== exp_r.yaw_difference) begin
                        $display("%0t: yaw_difference expected %0d actual %0d",
                                 $time, exp_r.yaw_difference, m_item.yaw_difference);
                        mismatches++;
                    end
                end
            end
            // Predict the item accepted on this edge.
            if (s_valid && s_ready)
                expected_results.push_back(score_edge(s_item));
            // Track register writes.
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TOLERANCE: tolerance = cfg_wdata[14:0];
                    CFG_WEIGHT:    weight = cfg_wdata;
                    CFG_THRESHOLD: thresh_on = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        outstanding = expected_results.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ehgys_pkg::*;

    localparam int LATENCY = CORDIC_STEPS_DEF + 8;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    int          mismatches;
    int          outstanding;
    int          cycles;
    logic        calm;
    logic        hold_req;
    logic        hold_done;

    edge_heading_goal_yaw_scorer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    yaw_score_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Offer one edge and hold it until taken; called at a falling edge.
    task automatic send_edge(input in_item_t it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_item = it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Wait for every outstanding result, then let the pipeline settle.
    task automatic drain();
        while (outstanding != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_regs(input logic [14:0] tol, input logic [15:0] wt,
                              input logic thr);
        cfg_we = 1'b1;
        cfg_index = CFG_TOLERANCE;
        cfg_wdata = {1'b0, tol};
        @(negedge aclk);
        cfg_index = CFG_WEIGHT;
        cfg_wdata = wt;
        @(negedge aclk);
        cfg_index = CFG_THRESHOLD;
        cfg_wdata = {15'd0, thr};
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed(32'($urandom_range(0, 2000))) - 1000;
            2: return $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_quat();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endfunction

    // Mostly final edges with a goal; some degenerate and malformed ones.
    function automatic in_item_t random_edge();
        in_item_t it;
        int kind;
        kind = $urandom_range(0, 19);
        it.is_end_edge = (kind != 0);
        it.goal_pose_given = (kind != 1);
        it.start_x = rand_coord();
        it.start_y = rand_coord();
        it.end_x = rand_coord();
        it.end_y = rand_coord();
        if (kind == 2) begin
            it.end_x = it.start_x;
            it.end_y = it.start_y;
        end else if (kind == 3) begin
            it.end_y = it.start_y;
        end
        it.quat_x = rand_quat();
        it.quat_y = rand_quat();
        it.quat_z = rand_quat();
        it.quat_w = rand_quat();
        if (kind == 4) begin
            // Goal terms cancel to a zero vector.
            it.quat_x = 0; it.quat_w = 0; it.quat_y = 8192; it.quat_z = 8192;
        end
        return it;
    endfunction

    function automatic in_item_t make_edge(input logic fin, input logic given,
        input logic signed [31:0] sx, input logic signed [31:0] sy,
        input logic signed [31:0] ex, input logic signed [31:0] ey,
        input logic signed [15:0] qx, input logic signed [15:0] qy,
        input logic signed [15:0] qz, input logic signed [15:0] qw);
        in_item_t it;
        it = '{fin, given, sx, sy, ex, ey, qx, qy, qz, qw};
        return it;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_edge(random_edge());
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TOLERANCE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_item = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed edges under the reset settings.
        send_edge(make_edge(1, 0, 0, 0, 100, 0, 0, 0, 0, 16384));
        send_edge(make_edge(0, 0, 0, 0, 100, 0, 0, 0, 0, 16384));
        send_edge(make_edge(0, 1, 0, 0, 100, 0, 0, 0, 0, 16384));
        send_edge(make_edge(1, 1, 0, 0, 65536, 0, 0, 0, 0, 16384));
        send_edge(make_edge(1, 1, 0, 0, 65536, 0, 0, 0, 16384, 0));
        send_edge(make_edge(1, 1, 0, 0, 0, 65536, 0, 0, 16384, 0));
        send_edge(make_edge(1, 1, 0, 0, -65536, -1, 0, 0, 11585, 11585));
        send_edge(make_edge(1, 1, 5, 5, 5, 5, 0, 0, 0, 16384));
        send_edge(make_edge(1, 1, 0, 0, 65536, 65536, 0, 8192, 8192, 0));
        send_edge(make_edge(1, 1, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 16384));
        send_edge(make_edge(1, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh8000_0000, 16384, 16384, 16384, 16384));
        send_edge(make_edge(1, 1, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0,
                            -16384, -16384, -16384, -16384));
        send_edge(make_edge(1, 1, 0, 0, 1, -1, -32768, -32768, -32768, -32768));
        send_edge(make_edge(1, 1, 0, 0, -1, 1, 32767, 32767, 32767, 32767));
        send_edge(make_edge(1, 1, 0, 0, 0, -1, 32767, -32768, 32767, -32768));
        send_edge(make_edge(1, 1, -1, -1, 0, 0, 0, 0, -16384, 16384));
        drain();

        // Extreme settings: zero tolerance with thresholding, full weight.
        write_regs(15'd0, 16'hFFFF, 1'b1);
        send_edge(make_edge(1, 1, 0, 0, 65536, 0, 0, 0, 0, 16384));
        send_edge(make_edge(1, 1, 0, 0, 65536, 0, 0, 0, 16384, 0));
        random_phase(250);
        drain();

        // Largest tolerance in range, zero weight.
        write_regs(15'd25736, 16'd0, 1'b1);
        random_phase(250);
        // Fill the pipeline while results are held back.
        hold_req = 1'b1;
        random_phase(250);
        drain();

        // Tolerance beyond range, smallest nonzero weight, thresholding off.
        write_regs(15'h7FFF, 16'd1, 1'b0);
        random_phase(250);
        drain();

        // Random settings, ending with no idling on either side.
        write_regs(15'($urandom_range(0, 25736)), 16'($urandom), 1'b1);
        random_phase(200);
        calm = 1'b1;
        random_phase(200);
        drain();

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
